// ===== hdl/tccw_pkg.sv =====
// tccw_pkg: shared types and constants of the text console cell writer
// no dependencies; imported by the screen memory and the top level
package tccw_pkg;

  // width of one character cell
  localparam int CELL_W = 8;

  // stream payload widths; the tdata widths are padded to whole bytes
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;

  // item kinds carried in tuser
  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } tccw_mode_e;

  // control bytes
  localparam logic [CELL_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CELL_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CELL_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CELL_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CELL_W-1:0] CH_BLANK     = 8'h20;

endpackage

// ===== hdl/tccw_addr_unit.sv =====
// tccw_addr_unit: shared cell address unit, one registered stage
// maps a screen row and column through the scroll ring offset to a memory address
module tccw_addr_unit #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic                              clk_i,
  input  logic [$clog2(ROWS)-1:0]           row_i,
  input  logic [$clog2(COLUMNS)-1:0]        col_i,
  input  logic [$clog2(ROWS)-1:0]           base_i,
  output logic [$clog2(ROWS)-1:0]           phys_o,
  output logic [$clog2(ROWS*COLUMNS)-1:0]   row_addr_o,
  output logic [$clog2(ROWS*COLUMNS)-1:0]   addr_o
);

  localparam int ROW_W = $clog2(ROWS);
  localparam int AW    = $clog2(ROWS * COLUMNS);

  logic [ROW_W:0]   sum;
  logic [ROW_W-1:0] phys;
  logic [AW-1:0]    row_addr;

  // ring position: row plus offset, wrapped once
  assign sum  = {1'b0, row_i} + {1'b0, base_i};
  assign phys = (sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(sum - (ROW_W+1)'(ROWS)) : ROW_W'(sum);
  assign row_addr = AW'(phys * COLUMNS);

  always_ff @(posedge clk_i) begin
    phys_o     <= phys;
    row_addr_o <= row_addr;
    addr_o     <= row_addr + AW'(col_i);
  end

endmodule

// ===== hdl/tccw_screen_ram.sv =====
// tccw_screen_ram: character cell memory, one write and one registered read port
// depends on tccw_pkg for the cell width
module tccw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [tccw_pkg::CELL_W-1:0] wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [tccw_pkg::CELL_W-1:0] rdata_o
);

  import tccw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/text_console_cell_writer_unit.sv =====
// text_console_cell_writer_unit: text console engine, top level and sequencer
// depends on tccw_pkg, tccw_addr_unit and tccw_screen_ram
//
// channel   dir  handshake                        payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tuser mode, tdata char/row/col
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata cell/column/line/scrolled
//
// printed byte or backspace (not at the left edge): decode, write check and done; a row sweep
//   is added when the target row is not yet live (first write after reset, clear or scroll sweeps it)
// read on the screen: decode, read address, read data and done; any other item: decode and done
// scrolling moves a ring offset and retires a row valid bit, so no rows are copied
// reset clears row valid bits, cursor and offset at once; no clearing pass is needed
// a stalled result sits in the output register; the next item waits only in the done state
module text_console_cell_writer_unit #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] char_code, [12:8] read_row, [19:13] read_col, [23:20] zero
  input  logic [tccw_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] mode
  input  logic [tccw_pkg::IN_TUSER_W-1:0] s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [7:0] cell_value, [14:8] column_now, [19:15] line_now, [20] scrolled, [23:21] zero
  output logic [tccw_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  import tccw_pkg::*;

  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int PH_W  = $clog2(TAB_STOP);
  localparam int AW    = $clog2(ROWS * COLUMNS);
  localparam int TT_W  = COL_W + 5;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_RADDR  = 7'b0000100,
    S_RDATA  = 7'b0001000,
    S_WCHK   = 7'b0010000,
    S_SWEEP  = 7'b0100000,
    S_DONE   = 7'b1000000
  } tccw_state_e;

  tccw_state_e state_q, state_d;

  // latched request
  tccw_mode_e   mode_q;
  logic [7:0]   char_q;
  logic [4:0]   rrow_q;
  logic [6:0]   rcol_q;

  // cursor, tab phase (column modulo tab stop), ring offset, live rows
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] line_q, line_d;
  logic [PH_W-1:0]  phase_q, phase_d;
  logic [ROW_W-1:0] base_q, base_d;
  logic [ROWS-1:0]  rv_q, rv_d;

  // result being built
  logic              scr_q, scr_d;
  logic [CELL_W-1:0] cell_q, cell_d;

  // row sweep
  logic [COL_W-1:0] sw_cnt_q, sw_cnt_d;
  logic [AW-1:0]    sw_addr_q, sw_addr_d;

  // output register
  logic              m_valid_q, m_valid_d;
  logic [CELL_W-1:0] o_cell_q, o_cell_d;
  logic [6:0]        o_col_q, o_col_d;
  logic [4:0]        o_line_q, o_line_d;
  logic              o_scr_q, o_scr_d;

  // address unit and memory
  logic [ROW_W-1:0]  au_row, au_phys;
  logic [COL_W-1:0]  au_col;
  logic [AW-1:0]     au_row_addr, au_addr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata, rdata;

  logic              in_accept;
  logic              is_bs;
  logic [COL_W-1:0]  wcol;
  logic [CELL_W-1:0] wbyte;
  logic              in_range;
  logic [TT_W-1:0]   tab_t;
  logic              do_nl, do_adv, do_back, wr_done;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign is_bs    = (char_q == CH_BACKSPACE);
  assign wcol     = is_bs ? col_q - COL_W'(1) : col_q;
  assign wbyte    = is_bs ? CH_BLANK : char_q;
  assign in_range = (int'(rrow_q) < ROWS) && (int'(rcol_q) < COLUMNS);
  // next tab stop: column minus its phase plus one stop
  assign tab_t    = TT_W'(col_q) - TT_W'(phase_q) + TT_W'(TAB_STOP);

  // reads go to the requested cell, writes to the cursor row
  assign au_row = (mode_q == MODE_READ) ? ROW_W'(rrow_q) : line_q;
  assign au_col = (mode_q == MODE_READ) ? COL_W'(rcol_q) : wcol;

  tccw_addr_unit #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_addr (
    .clk_i      (clk_i),
    .row_i      (au_row),
    .col_i      (au_col),
    .base_i     (base_q),
    .phys_o     (au_phys),
    .row_addr_o (au_row_addr),
    .addr_o     (au_addr)
  );

  tccw_screen_ram #(
    .DEPTH (ROWS * COLUMNS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (au_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    line_d    = line_q;
    phase_d   = phase_q;
    base_d    = base_q;
    rv_d      = rv_q;
    scr_d     = scr_q;
    cell_d    = cell_q;
    sw_cnt_d  = sw_cnt_q;
    sw_addr_d = sw_addr_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    o_cell_d  = o_cell_q;
    o_col_d   = o_col_q;
    o_line_d  = o_line_q;
    o_scr_d   = o_scr_q;
    we        = 1'b0;
    waddr     = au_addr;
    wdata     = wbyte;
    do_nl     = 1'b0;
    do_adv    = 1'b0;
    do_back   = 1'b0;
    wr_done   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          scr_d   = 1'b0;
          cell_d  = '0;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        unique case (mode_q)
          MODE_PUT: begin
            priority if (char_q == CH_NEWLINE) begin
              do_nl = 1'b1;
            end else if (char_q == CH_RETURN) begin
              col_d   = '0;
              phase_d = '0;
            end else if (char_q == CH_TAB) begin
              if (tab_t >= TT_W'(COLUMNS)) begin
                do_nl = 1'b1;
              end else begin
                col_d   = COL_W'(tab_t);
                phase_d = '0;
              end
            end else if (is_bs && col_q == '0) begin
              // backspace at the left edge does nothing
            end else begin
              state_d = S_WCHK;
            end
          end
          MODE_READ: begin
            if (in_range) begin
              state_d = S_RADDR;
            end
          end
          MODE_CLEAR: begin
            rv_d    = '0;
            col_d   = '0;
            line_d  = '0;
            phase_d = '0;
            base_d  = '0;
          end
          default: begin
            // unused kind: no change
          end
        endcase
      end
      S_RADDR: begin
        state_d = S_RDATA;
      end
      S_RDATA: begin
        // a row not yet live reads as zero
        cell_d  = rv_q[au_phys] ? rdata : '0;
        state_d = S_DONE;
      end
      S_WCHK: begin
        if (rv_q[au_phys]) begin
          we      = 1'b1;
          wr_done = 1'b1;
          state_d = S_DONE;
        end else begin
          sw_cnt_d  = '0;
          sw_addr_d = au_row_addr;
          state_d   = S_SWEEP;
        end
      end
      S_SWEEP: begin
        // zero the row, dropping the byte in at its column
        we    = 1'b1;
        waddr = sw_addr_q;
        wdata = (sw_cnt_q == wcol) ? wbyte : '0;
        if (sw_cnt_q == COL_W'(COLUMNS - 1)) begin
          rv_d[au_phys] = 1'b1;
          wr_done       = 1'b1;
          state_d       = S_DONE;
        end else begin
          sw_cnt_d  = sw_cnt_q + COL_W'(1);
          sw_addr_d = sw_addr_q + AW'(1);
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          o_cell_d  = cell_q;
          o_col_d   = 7'(col_q);
          o_line_d  = 5'(line_q);
          o_scr_d   = scr_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // cursor move after a cell write
    if (wr_done) begin
      priority if (is_bs) begin
        do_back = 1'b1;
      end else if (col_q == COL_W'(COLUMNS - 1)) begin
        do_nl = 1'b1;
      end else begin
        do_adv = 1'b1;
      end
    end

    if (do_adv) begin
      col_d   = col_q + COL_W'(1);
      phase_d = (phase_q == PH_W'(TAB_STOP - 1)) ? '0 : phase_q + PH_W'(1);
    end

    if (do_back) begin
      col_d   = col_q - COL_W'(1);
      phase_d = (phase_q == '0) ? PH_W'(TAB_STOP - 1) : phase_q - PH_W'(1);
    end

    // next line; below the last line the ring turns and the old top row is retired, reading as zero
    if (do_nl) begin
      col_d   = '0;
      phase_d = '0;
      if (line_q == ROW_W'(ROWS - 1)) begin
        base_d       = (base_q == ROW_W'(ROWS - 1)) ? '0 : base_q + ROW_W'(1);
        rv_d[base_q] = 1'b0;
        scr_d        = 1'b1;
      end else begin
        line_d = line_q + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      col_q     <= '0;
      line_q    <= '0;
      phase_q   <= '0;
      base_q    <= '0;
      rv_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      line_q    <= line_d;
      phase_q   <= phase_d;
      base_q    <= base_d;
      rv_q      <= rv_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= tccw_mode_e'(s_axis_tuser_i[1:0]);
      char_q <= s_axis_tdata_i[7:0];
      rrow_q <= s_axis_tdata_i[12:8];
      rcol_q <= s_axis_tdata_i[19:13];
    end
    scr_q     <= scr_d;
    cell_q    <= cell_d;
    sw_cnt_q  <= sw_cnt_d;
    sw_addr_q <= sw_addr_d;
    o_cell_q  <= o_cell_d;
    o_col_q   <= o_col_d;
    o_line_q  <= o_line_d;
    o_scr_q   <= o_scr_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b000, o_scr_q, o_line_q, o_col_q, o_cell_q};

  // cursor and ring offset stay on the screen
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(col_q) < COLUMNS) else $error("cursor column off screen");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(line_q) < ROWS) && (int'(base_q) < ROWS)) else $error("cursor row or offset off screen");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(phase_q) < TAB_STOP) else $error("tab phase out of range");

  // a clear item leaves no live row and a homed cursor
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECODE && mode_q == MODE_CLEAR) |=>
      (rv_q == '0 && col_q == '0 && line_q == '0)) else $error("clear left state behind");

  // a sweep ends in the done state after its last column
  a_sweep_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && sw_cnt_q == COL_W'(COLUMNS - 1)) |=> (state_q == S_DONE))
    else $error("row sweep did not finish");

endmodule

// ===== test/tb.sv =====
// tb: self-checking testbench for text_console_cell_writer_unit
// depends on tccw_pkg and the block's RTL; predicts each reply from its own screen model
// directed items first, then random bursts of text, control bytes, reads, clears and noise
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;

  localparam int          RANDOM_ITEMS = 650;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          DRAIN_CYCLES = 120;   // slowest item: row sweep plus write
  localparam int          HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int          MARK_SPACING = 150;   // items between drain pauses
  localparam logic [1:0]  MODE_SPARE   = 2'd3;  // unused kind, must change nothing

  // one input item, or a marker that makes the sender wait for every reply
  typedef struct {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
    bit         wait_drain;
  } console_item_t;

  // reply layout, lowest field in the lowest bits
  typedef struct packed {
    logic [2:0] pad;
    logic       scrolled;
    logic [4:0] line;
    logic [6:0] col;
    logic [7:0] cell_value;
  } console_reply_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  console_item_t  items_to_send[$];
  console_reply_t replies_due[$];

  // screen and cursor as the block should hold them
  logic [7:0] screen_model [ROWS][COLUMNS];
  int         cursor_col;
  int         cursor_line;

  int  items_total;     // real items queued, markers excluded
  int  items_taken;     // items accepted by the block
  int  replies_seen;
  int  fail_count;
  bit  item_taken_now;  // input handshake at the latest rising edge

  // sender state
  int  gap_left;
  bit  drain_wait;

  // receiver state
  int  stall_left;
  int  hold_left;
  int  hold_mark = 40;

  text_console_cell_writer_unit #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // ---------------------------------------------------------------------------
  // screen model
  // ---------------------------------------------------------------------------

  function automatic void screen_clear();
    int r, c;
    for (r = 0; r < ROWS; r++)
      for (c = 0; c < COLUMNS; c++)
        screen_model[r][c] = 8'h00;
    cursor_col  = 0;
    cursor_line = 0;
  endfunction

  // column 0 of the next line; past the last line the screen moves up one row
  function automatic bit line_feed();
    int r, c;
    cursor_col = 0;
    if (cursor_line + 1 < ROWS) begin
      cursor_line++;
      return 1'b0;
    end
    for (r = 0; r < ROWS - 1; r++)
      for (c = 0; c < COLUMNS; c++)
        screen_model[r][c] = screen_model[r+1][c];
    for (c = 0; c < COLUMNS; c++)
      screen_model[ROWS-1][c] = 8'h00;
    return 1'b1;
  endfunction

  // applies one item to the model and gives the reply it should cause
  function automatic console_reply_t console_apply(console_item_t it);
    console_reply_t rep;
    int             stop;
    rep = '0;
    if (it.mode == MODE_PUT) begin
      if (it.char_code == CH_NEWLINE) begin
        rep.scrolled = line_feed();
      end else if (it.char_code == CH_RETURN) begin
        cursor_col = 0;
      end else if (it.char_code == CH_TAB) begin
        stop = cursor_col - (cursor_col % TAB_STOP) + TAB_STOP;
        // a tab that reaches the width wraps like a printed byte
        if (stop >= COLUMNS) rep.scrolled = line_feed();
        else cursor_col = stop;
      end else if (it.char_code == CH_BACKSPACE) begin
        if (cursor_col > 0) begin
          cursor_col--;
          screen_model[cursor_line][cursor_col] = CH_BLANK;
        end
      end else begin
        screen_model[cursor_line][cursor_col] = it.char_code;
        cursor_col++;
        if (cursor_col >= COLUMNS) rep.scrolled = line_feed();
      end
    end else if (it.mode == MODE_READ) begin
      // reads outside the screen give zero
      if (it.read_row < ROWS && it.read_col < COLUMNS)
        rep.cell_value = screen_model[it.read_row][it.read_col];
    end else if (it.mode == MODE_CLEAR) begin
      screen_clear();
    end
    rep.col  = cursor_col[6:0];
    rep.line = cursor_line[4:0];
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic console_item_t make_item(logic [1:0] mode, logic [7:0] ch,
                                              logic [4:0] row, logic [6:0] col);
    console_item_t it;
    it.mode       = mode;
    it.char_code  = ch;
    it.read_row   = row;
    it.read_col   = col;
    it.wait_drain = 1'b0;
    return it;
  endfunction

  // unused fields carry random bits so every bit toggles
  function automatic console_item_t put_item(logic [7:0] ch);
    return make_item(MODE_PUT, ch, 5'($urandom), 7'($urandom));
  endfunction

  function automatic console_item_t read_item_on_screen();
    return make_item(MODE_READ, 8'($urandom), 5'($urandom_range(0, ROWS - 1)),
                     7'($urandom_range(0, COLUMNS - 1)));
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // ordinary console traffic: mostly text, a fair share of control bytes
  function automatic console_item_t mixed_item();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40)      return put_item(printable());
    else if (r < 50) return put_item(8'($urandom));
    else if (r < 60) return put_item(CH_NEWLINE);
    else if (r < 68) return put_item(CH_TAB);
    else if (r < 78) return put_item(CH_BACKSPACE);
    else if (r < 83) return put_item(CH_RETURN);
    else if (r < 95) return read_item_on_screen();
    else if (r < 97) return make_item(MODE_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
    else             return make_item(MODE_SPARE, 8'($urandom), 5'($urandom), 7'($urandom));
  endfunction

  // most gaps short, a few long
  function automatic int idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50)      return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else             return $urandom_range(20, 60);
  endfunction

  // a stretch of the run with no idling on either side
  function automatic bit quiet_window(int n);
    return n >= 250 && n < 330;
  endfunction

  function automatic void queue_item(console_item_t it);
    items_to_send.push_back(it);
    items_total++;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender: offers items at the falling edge, holds each until accepted
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    console_item_t nxt;
    bit            offer;
    if (rst_ni && (!s_axis_tvalid_i || item_taken_now)) begin
      offer = 1'b0;
      if (drain_wait) begin
        // pause until every reply is in
        if (replies_due.size() == 0) drain_wait = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
      end else begin
        while (!offer && !drain_wait && items_to_send.size() > 0) begin
          nxt = items_to_send.pop_front();
          if (nxt.wait_drain) drain_wait = 1'b1;
          else offer = 1'b1;
        end
      end
      if (offer) begin
        s_axis_tdata_i <= {4'b0000, nxt.read_col, nxt.read_row, nxt.char_code};
        s_axis_tuser_i <= nxt.mode;
        gap_left = quiet_window(items_taken) ? 0 : idle_length();
      end
      s_axis_tvalid_i <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls plus long hold-offs that back the block up
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    bit ready;
    if (replies_seen >= hold_mark) begin
      hold_left = HOLD_CYCLES;
      hold_mark += 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      ready = 1'b0;
    end else begin
      if (!quiet_window(replies_seen) && $urandom_range(0, 3) == 0)
        stall_left = idle_length();
      ready = (stall_left == 0);
    end
    m_axis_tready_i <= ready;
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each accepted item, checks each accepted reply
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    console_item_t  it;
    console_reply_t want;
    console_reply_t got;
    item_taken_now = rst_ni && ((s_axis_tvalid_i && s_axis_tready_o) === 1'b1);
    if (item_taken_now) begin
      it = make_item(s_axis_tuser_i, s_axis_tdata_i[7:0], s_axis_tdata_i[12:8],
                     s_axis_tdata_i[19:13]);
      replies_due.push_back(console_apply(it));
      items_taken++;
    end
    if (rst_ni && ((m_axis_tvalid_o && m_axis_tready_i) === 1'b1)) begin
      replies_seen++;
      got = m_axis_tdata_o;
      if (replies_due.size() == 0) begin
        $error("reply with nothing expected: tdata %h", m_axis_tdata_o);
        fail_count++;
      end else begin
        want = replies_due.pop_front();
        check_field("cell_value", 32'(want.cell_value), 32'(got.cell_value));
        check_field("column_now", 32'(want.col), 32'(got.col));
        check_field("line_now", 32'(want.line), 32'(got.line));
        check_field("scrolled", 32'(want.scrolled), 32'(got.scrolled));
        check_field("padding", 32'(want.pad), 32'(got.pad));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    console_item_t marker;
    int            n_random;
    int            last_mark;
    int            len;
    int            k;
    int unsigned   p;

    screen_clear();
    marker = make_item(MODE_PUT, 8'h00, 5'd0, 7'd0);
    marker.wait_drain = 1'b1;

    // directed part
    queue_item(make_item(MODE_CLEAR, 8'hFF, 5'd31, 7'd127));
    queue_item(make_item(MODE_PUT, 8'h41, 5'd0, 7'd0));
    queue_item(make_item(MODE_PUT, 8'h00, 5'd0, 7'd0));     // zero byte is printed
    queue_item(make_item(MODE_PUT, 8'hFF, 5'd31, 7'd127));
    queue_item(make_item(MODE_READ, 8'h00, 5'd0, 7'd0));
    queue_item(make_item(MODE_READ, 8'hFF, 5'd0, 7'd2));
    queue_item(make_item(MODE_PUT, CH_BACKSPACE, 5'd0, 7'd0));
    queue_item(make_item(MODE_READ, 8'h00, 5'd0, 7'd2));    // now blank
    queue_item(make_item(MODE_PUT, CH_RETURN, 5'd0, 7'd0));
    queue_item(make_item(MODE_PUT, CH_BACKSPACE, 5'd0, 7'd0)); // at column zero
    queue_item(make_item(MODE_PUT, CH_TAB, 5'd0, 7'd0));
    queue_item(make_item(MODE_PUT, 8'h78, 5'd0, 7'd0));
    queue_item(make_item(MODE_READ, 8'h00, 5'd0, 7'd8));
    queue_item(make_item(MODE_PUT, CH_NEWLINE, 5'd0, 7'd0));
    queue_item(make_item(MODE_READ, 8'h00, 5'd24, 7'd79));  // last cell
    queue_item(make_item(MODE_READ, 8'h00, 5'd25, 7'd0));   // row off the screen
    queue_item(make_item(MODE_READ, 8'hFF, 5'd31, 7'd127));
    queue_item(make_item(MODE_READ, 8'h00, 5'd0, 7'd80));   // column off the screen
    queue_item(make_item(MODE_SPARE, 8'hFF, 5'd31, 7'd127));
    queue_item(make_item(MODE_SPARE, 8'h00, 5'd0, 7'd0));
    for (k = 0; k < 4; k++) queue_item(make_item(MODE_PUT, CH_TAB, 5'd0, 7'd0));
    items_to_send.push_back(marker);

    // random part, in bursts
    n_random  = 0;
    last_mark = items_total;
    while (n_random < RANDOM_ITEMS) begin
      p = $urandom_range(0, 99);
      if (p < 40) begin
        len = 20;
        for (k = 0; k < len; k++) queue_item(mixed_item());
      end else if (p < 55) begin
        // long line, wraps at the width
        len = $urandom_range(70, 100);
        for (k = 0; k < len; k++) queue_item(put_item(printable()));
      end else if (p < 67) begin
        // line feeds down to the bottom and on into scrolling
        len = $urandom_range(5, 30);
        for (k = 0; k < len; k++)
          queue_item(put_item(($urandom_range(0, 3) == 0) ? printable() : CH_NEWLINE));
      end else if (p < 77) begin
        // tabs across a line, wrapping at the width
        len = $urandom_range(4, 14);
        for (k = 0; k < len; k++)
          queue_item(put_item(($urandom_range(0, 4) == 0) ? printable() : CH_TAB));
      end else if (p < 89) begin
        len = 10;
        for (k = 0; k < len; k++) queue_item(read_item_on_screen());
      end else if (p < 96) begin
        // noise: any kind, any field value
        len = 10;
        for (k = 0; k < len; k++)
          queue_item(make_item(2'($urandom), 8'($urandom), 5'($urandom), 7'($urandom)));
      end else begin
        len = 3;
        queue_item(make_item(MODE_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom)));
        queue_item(put_item(printable()));
        queue_item(read_item_on_screen());
      end
      n_random += len;
      if (items_total - last_mark >= MARK_SPACING) begin
        items_to_send.push_back(marker);
        last_mark = items_total;
      end
    end

    repeat (12) @(posedge clk_i);
    #1 rst_ni = 1'b1;

    while (!(items_taken == items_total && replies_due.size() == 0)) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0 && replies_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tccw_pkg.sv
hdl/tccw_addr_unit.sv
hdl/tccw_screen_ram.sv
hdl/text_console_cell_writer_unit.sv
test/tb.sv
